// File: sv/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Depends on nothing; each file that asserts includes it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of clk, ignored while arst_n is low.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Implication checked at every rising edge of clk, ignored while arst_n is low.
`define ASSERT_IMPL(label, ante, cons, msg) \
	`ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

// File: sv/clbce_pkg.sv
// Types and constants shared by the character LCD bus cycle engine.
// Depends on nothing; every other file of the block but assert_macros.svh imports it.
package clbce_pkg;

	localparam int unsigned PADDR_W = 4;
	localparam int unsigned PDATA_W = 32;

	// Register map, indexed by paddr[3:2]
	localparam logic [1:0] REG_SETUP  = 2'd0;
	localparam logic [1:0] REG_ENABLE = 2'd1;
	localparam logic [1:0] REG_HOLD   = 2'd2;
	localparam logic [1:0] REG_POLL   = 2'd3;

	localparam logic [15:0] SETUP_RST  = 16'd5;
	localparam logic [15:0] ENABLE_RST = 16'd15;
	localparam logic [15:0] HOLD_RST   = 16'd10;
	localparam logic [10:0] POLL_RST   = 11'd1024;

	// Request opcodes
	localparam logic [1:0] OP_DATA = 2'd0;
	localparam logic [1:0] OP_CMD  = 2'd1;
	localparam logic [1:0] OP_POLL = 2'd2;
	localparam logic [1:0] OP_NONE = 2'd3;

	localparam int unsigned BUSY_BIT = 7;

	typedef struct packed {
		logic [15:0] setup_ticks;
		logic [15:0] enable_ticks;
		logic [15:0] hold_ticks;
		logic [10:0] poll_limit;
	} cfg_t;

	typedef struct packed {
		logic       start_req;
		logic [1:0] opcode;
		logic [7:0] value;
		logic [7:0] bus_in;
	} cmd_t;

	typedef struct packed {
		logic       pin_en;
		logic       pin_rs;
		logic       pin_rw;
		logic [7:0] bus_out;
		logic       bus_drive;
		logic       ready_res;
		logic       done_res;
		logic       not_busy;
		logic [7:0] status_byte;
	} res_t;

endpackage

// File: sv/clbce_ifs.sv
// Valid/ready channel interfaces for the tick items and the pin results.
// Depends on clbce_pkg for the payload types.
interface clbce_cmd_if import clbce_pkg::*; ();
	logic valid;
	logic ready;
	cmd_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface clbce_res_if import clbce_pkg::*; ();
	logic valid;
	logic ready;
	res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: sv/clbce_cfg.sv
// APB-style register file holding the bus timing and poll limit.
// Depends on clbce_pkg for the register map and cfg_t.
module clbce_cfg import clbce_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output cfg_t               cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setup_ticks  <= SETUP_RST;
			cfg_q.enable_ticks <= ENABLE_RST;
			cfg_q.hold_ticks   <= HOLD_RST;
			cfg_q.poll_limit   <= POLL_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_SETUP:  cfg_q.setup_ticks  <= pwdata[15:0];
				REG_ENABLE: cfg_q.enable_ticks <= pwdata[15:0];
				REG_HOLD:   cfg_q.hold_ticks   <= pwdata[15:0];
				REG_POLL:   cfg_q.poll_limit   <= pwdata[10:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_SETUP:  prdata = {16'd0, cfg_q.setup_ticks};
			REG_ENABLE: prdata = {16'd0, cfg_q.enable_ticks};
			REG_HOLD:   prdata = {16'd0, cfg_q.hold_ticks};
			REG_POLL:   prdata = {21'd0, cfg_q.poll_limit};
			default:    prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// File: sv/clbce_core.sv
// Bus cycle sequencer: phase state, tick and retry counters, pin decode.
// Depends on clbce_pkg for opcodes, cfg_t, cmd_t and res_t.
module clbce_core import clbce_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  cmd_t item,
	input  cfg_t cfg,
	output res_t result
);

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_SETUP  = 2'd1;
	localparam logic [1:0] PH_ENABLE = 2'd2;
	localparam logic [1:0] PH_HOLD   = 2'd3;

	logic [1:0]  phase_q, phase_n;
	logic [15:0] tick_q, tick_n;
	logic [1:0]  op_q, op_n;
	logic [7:0]  byte_q, byte_n;
	logic [10:0] try_q, try_n;
	logic [7:0]  sampled_q, sampled_n;
	logic        drive_q, drive_n;
	logic [15:0] sel_len, len;
	logic        over, done, nb, active;

	// Length of the current phase; a zero register counts as one tick.
	always_comb begin
		case (phase_q)
			PH_SETUP:  sel_len = cfg.setup_ticks;
			PH_ENABLE: sel_len = cfg.enable_ticks;
			default:   sel_len = cfg.hold_ticks;
		endcase
		len  = (sel_len == 16'd0) ? 16'd1 : sel_len;
		over = (tick_q >= len);
	end

	always_comb begin
		phase_n = phase_q;
		tick_n  = tick_q;
		op_n    = op_q;
		byte_n  = byte_q;
		try_n   = try_q;
		drive_n = drive_q;
		done    = 1'b0;
		nb      = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (item.start_req && (item.opcode != OP_NONE)) begin
					op_n    = item.opcode;
					byte_n  = (item.opcode == OP_POLL) ? 8'd0 : item.value;
					drive_n = (item.opcode != OP_POLL);
					try_n   = 11'd0;
					phase_n = PH_SETUP;
					tick_n  = 16'd1;
				end
			end
			PH_SETUP, PH_ENABLE: begin
				if (over) begin
					phase_n = (phase_q == PH_SETUP) ? PH_ENABLE : PH_HOLD;
					tick_n  = 16'd1;
				end else begin
					tick_n = tick_q + 16'd1;
				end
			end
			default: begin
				if (!over) begin
					tick_n = tick_q + 16'd1;
				end else if (op_q != OP_POLL) begin
					phase_n = PH_IDLE;
					drive_n = 1'b0;
					tick_n  = 16'd0;
					done    = 1'b1;
				end else if (!sampled_q[BUSY_BIT]) begin
					phase_n = PH_IDLE;
					tick_n  = 16'd0;
					done    = 1'b1;
					nb      = 1'b1;
				end else if (try_q >= cfg.poll_limit) begin
					phase_n = PH_IDLE;
					tick_n  = 16'd0;
					done    = 1'b1;
				end else begin
					try_n   = try_q + 11'd1;
					phase_n = PH_SETUP;
					tick_n  = 16'd1;
				end
			end
		endcase
		// The status byte is captured on every tick that EN is high in a poll.
		sampled_n = ((phase_n == PH_ENABLE) && (op_n == OP_POLL)) ? item.bus_in : sampled_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			tick_q    <= '0;
			op_q      <= '0;
			byte_q    <= '0;
			try_q     <= '0;
			sampled_q <= '0;
			drive_q   <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_n;
			tick_q    <= tick_n;
			op_q      <= op_n;
			byte_q    <= byte_n;
			try_q     <= try_n;
			sampled_q <= sampled_n;
			drive_q   <= drive_n;
		end
	end

	// Pin levels for this tick, taken from the state after its transition.
	always_comb begin
		active             = (phase_n != PH_IDLE);
		result.pin_en      = (phase_n == PH_ENABLE);
		result.pin_rs      = active && (op_n == OP_DATA);
		result.pin_rw      = !active || (op_n == OP_POLL);
		result.bus_out     = drive_n ? byte_n : 8'd0;
		result.bus_drive   = drive_n;
		result.ready_res   = !active;
		result.done_res    = done;
		result.not_busy    = nb;
		result.status_byte = sampled_n;
	end

endmodule

// File: sv/char_lcd_bus_cycle_engine.sv
// Top level of the character LCD bus cycle engine: input register, sequencer
// and result register. Depends on clbce_pkg, clbce_ifs, clbce_cfg, clbce_core.
//
// Channel   Direction  Carries
// cmd       in         one clock tick: start_req, opcode, value, bus_in
// rsp       out        pin levels and status for that tick
// APB       in/out     timing registers and poll limit
//
// One tick item is accepted in every cycle while the result side keeps up.
// Each item is held in the input register and then passes through the
// sequencer into the result register.
// The sequencer state advances only when an item moves from the input
// register into the result register, so stalls on rsp freeze the bus timing.
// Reset clears the state to idle with the pins released and loads the
// default timing (setup 5, enable 15, hold 10, poll limit 1024).
module char_lcd_bus_cycle_engine import clbce_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	clbce_cmd_if.sink          cmd,
	clbce_res_if.source        rsp
);

	cfg_t cfg;
	logic in_valid_s1;
	cmd_t in_data_s1;
	logic out_valid_s2;
	res_t out_data_s2;
	res_t step_res;
	logic advance;

	// The register file never inserts wait states.
	assign pready = 1'b1;

	clbce_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// An item advances when the result register is empty or is being
	// emptied by a transfer in this same cycle.
	assign advance   = in_valid_s1 && (!out_valid_s2 || rsp.ready);
	assign cmd.ready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			in_valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			in_data_s1 <= cmd.data;
		end
	end

	clbce_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (in_data_s1),
		.cfg    (cfg),
		.result (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_s2 <= step_res;
		end
	end

	assign rsp.valid = out_valid_s2;
	assign rsp.data  = out_data_s2;

endmodule

// File: sv/clbce_checker.sv
// Port-level checks on the result channel of the bus cycle engine.
// Depends on clbce_pkg and assert_macros.svh; bound to the top level below.
`include "assert_macros.svh"

module clbce_checker import clbce_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input res_t out_data
);

	`ASSERT_CLK(a_valid_held, (out_valid && !out_ready) |=> out_valid, "result dropped while stalled")
	`ASSERT_CLK(a_data_held, (out_valid && !out_ready) |=> $stable(out_data), "result changed while stalled")
	`ASSERT_IMPL(a_done_idle, out_valid && out_data.done_res, out_data.ready_res && !out_data.pin_en, "finish reported while bus cycle still active")
	`ASSERT_IMPL(a_nb_done, out_valid && out_data.not_busy, out_data.done_res && out_data.pin_rw && !out_data.bus_drive, "not_busy outside a finished poll")
	`ASSERT_IMPL(a_drive_write, out_valid && out_data.bus_drive, !out_data.pin_rw && !out_data.ready_res, "data pins driven outside a write cycle")

endmodule

bind char_lcd_bus_cycle_engine clbce_checker u_clbce_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (rsp.valid),
	.out_ready (rsp.ready),
	.out_data  (rsp.data)
);
